>>> src/qtbe_pkg.sv
// Shared constants, region type and helpers for the quadtree bitmap encoder.
package qtbe_pkg;

    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int LD_W        = DIM_W + 1;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int PIX_AW      = 2 * DIM_W;
    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_D    = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] r0;
        logic [DIM_W-1:0] r1;
        logic [DIM_W-1:0] c0;
        logic [DIM_W-1:0] c1;
    } region_t;

    localparam int REGION_W = $bits(region_t);

    // Map a programmed dimension onto 1..MAX_DIM.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (v > CFG_W'(MAX_DIM))
        begin
            r = CFG_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/qtbe_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module qtbe_ram #(
    parameter int WIDTH  = 1,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/quadtree_bitmap_encoder_core.sv
// Quadtree bitmap encoder top level: load control, region stack and scan sequencer.
//
//  channel   signals                           direction  transfer
//  --------  --------------------------------  ---------  ---------------------------
//  request   start, busy, func, pixel          in         start && !busy
//  result    done, symbol, last                out        done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,  in         cfg_valid && cfg_ready
//            cfg_data
//
// A pixel write request leaves busy low.
// A fetch request of a region that turns out uniform keeps busy high through one
// stack read, then one bitmap read per pixel through the scan unit (read
// and compare overlap), then the compare of the last pixel read.
// A region that splits stops scanning at the first mismatch and then steps
// through the four quadrant pushes in S_PUSH before busy drops.
// Reset clears the control state only; bitmap and stack contents are undefined
// until written. The result receiver cannot stall: done is a one-cycle strobe.
module quadtree_bitmap_encoder_core
    import qtbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic                 pixel,
    output logic                 done,
    output logic [1:0]           symbol,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_PUSH = 4'b1000
    } state_t;

    // Quadrant push order: reversed, so top-left comes off the stack first.
    typedef enum logic [1:0] {
        Q_BR = 2'd0,
        Q_BL = 2'd1,
        Q_TR = 2'd2,
        Q_TL = 2'd3
    } quad_t;

    state_t state_reg, state_next;
    quad_t  quad_reg, quad_next;

    // Configuration registers.
    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic [CFG_W-1:0] nr, nc;

    // Load position and stack bookkeeping.
    logic [DIM_W-1:0] load_row_reg, load_row_next;
    logic [DIM_W-1:0] load_col_reg, load_col_next;
    logic             loading_reg, loading_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Current region and scan unit state.
    region_t          region_reg, region_next;
    logic [DIM_W-1:0] scan_r_reg, scan_r_next;
    logic [DIM_W-1:0] scan_c_reg, scan_c_next;
    logic             issue_done_reg, issue_done_next;
    logic             first_reg, first_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_first_reg, pend_first_next;
    logic             pend_last_reg, pend_last_next;
    logic             val_reg, val_next;

    // Result registers.
    logic             done_reg, done_next;
    logic [1:0]       symbol_reg, symbol_next;
    logic             last_reg, last_next;

    // Memory ports.
    logic              pix_we;
    logic [PIX_AW-1:0] pix_waddr, pix_raddr;
    logic              pix_rdata;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    region_t           stk_wdata, stk_rdata;

    // Load stepping.
    logic             accept;
    logic [DIM_W-1:0] eff_row, eff_col;
    logic [LD_W-1:0]  col_inc, row_inc, row_new;
    logic             wrap_col, load_end;

    // Scan compare and split point.
    logic             ref_bit, mismatch, uniform, issue_last;
    logic [LD_W-1:0]  rm_sum, cm_sum;
    logic [DIM_W-1:0] rm, cm;
    logic             right, below, quad_ok;
    region_t          quad_region;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    assign nr = clamp_dim(rows_reg);
    assign nc = clamp_dim(cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(1);
            cols_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS: rows_reg <= cfg_data;
                REG_COLS: cols_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // A write after loading finished starts a new image at the origin.
    assign eff_row  = loading_reg ? load_row_reg : '0;
    assign eff_col  = loading_reg ? load_col_reg : '0;
    assign col_inc  = {1'b0, eff_col} + LD_W'(1);
    assign wrap_col = (col_inc >= LD_W'(nc));
    assign row_inc  = {1'b0, eff_row} + LD_W'(1);
    assign row_new  = wrap_col ? row_inc : {1'b0, eff_row};
    assign load_end = (row_new >= LD_W'(nr));

    // Split point is the floor of the midpoint; empty quadrants are skipped.
    assign rm_sum = {1'b0, region_reg.r0} + {1'b0, region_reg.r1};
    assign cm_sum = {1'b0, region_reg.c0} + {1'b0, region_reg.c1};
    assign rm     = rm_sum[LD_W-1:1];
    assign cm     = cm_sum[LD_W-1:1];
    assign right  = (cm < region_reg.c1);
    assign below  = (rm < region_reg.r1);

    always_comb
    begin
        quad_region = region_reg;
        quad_ok     = 1'b1;
        case (quad_reg)
            Q_BR:
            begin
                quad_region.r0 = rm + DIM_W'(1);
                quad_region.c0 = cm + DIM_W'(1);
                quad_ok        = below && right;
            end
            Q_BL:
            begin
                quad_region.r0 = rm + DIM_W'(1);
                quad_region.c1 = cm;
                quad_ok        = below;
            end
            Q_TR:
            begin
                quad_region.r1 = rm;
                quad_region.c0 = cm + DIM_W'(1);
                quad_ok        = right;
            end
            Q_TL:
            begin
                quad_region.r1 = rm;
                quad_region.c1 = cm;
            end
            default: quad_ok = 1'b0;
        endcase
    end

    // Compare the pixel that came back against the region's top-left pixel.
    assign ref_bit    = pend_first_reg ? pix_rdata : val_reg;
    assign mismatch   = pend_valid_reg && (pix_rdata != ref_bit);
    assign uniform    = pend_valid_reg && pend_last_reg && !mismatch;
    assign issue_last = (scan_r_reg == region_reg.r1) && (scan_c_reg == region_reg.c1);

    assign pix_raddr = {scan_r_reg, scan_c_reg};
    assign stk_raddr = STK_AW'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        quad_next       = quad_reg;
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        loading_next    = loading_reg;
        count_next      = count_reg;
        region_next     = region_reg;
        scan_r_next     = scan_r_reg;
        scan_c_next     = scan_c_reg;
        issue_done_next = issue_done_reg;
        first_next      = first_reg;
        pend_valid_next = 1'b0;
        pend_first_next = 1'b0;
        pend_last_next  = 1'b0;
        val_next        = val_reg;
        done_next       = 1'b0;
        symbol_next     = symbol_reg;
        last_next       = last_reg;
        pix_we          = 1'b0;
        pix_waddr       = {eff_row, eff_col};
        stk_we          = 1'b0;
        stk_waddr       = STK_AW'(count_reg);
        stk_wdata       = quad_region;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == FUNC_WRITE))
                begin
                    // Store the pixel and advance in row-major order.
                    pix_we        = 1'b1;
                    loading_next  = 1'b1;
                    count_next    = '0;
                    load_row_next = row_new[DIM_W-1:0];
                    load_col_next = wrap_col ? '0 : col_inc[DIM_W-1:0];
                    if (load_end)
                    begin
                        // Push the whole image as the first region.
                        load_row_next = '0;
                        load_col_next = '0;
                        loading_next  = 1'b0;
                        count_next    = CNT_W'(1);
                        stk_we        = 1'b1;
                        stk_waddr     = '0;
                        stk_wdata.r0  = '0;
                        stk_wdata.r1  = DIM_W'(nr - CFG_W'(1));
                        stk_wdata.c0  = '0;
                        stk_wdata.c1  = DIM_W'(nc - CFG_W'(1));
                    end
                end
                else if (accept && (count_reg != '0))
                begin
                    // Pop the top region; its entry arrives next cycle.
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_POP;
                end
            end

            S_POP:
            begin
                region_next     = stk_rdata;
                scan_r_next     = stk_rdata.r0;
                scan_c_next     = stk_rdata.c0;
                issue_done_next = 1'b0;
                first_next      = 1'b1;
                state_next      = S_SCAN;
            end

            S_SCAN:
            begin
                if (mismatch)
                begin
                    done_next   = 1'b1;
                    symbol_next = SYM_D;
                    last_next   = 1'b0;
                    quad_next   = Q_BR;
                    state_next  = S_PUSH;
                end
                else if (uniform)
                begin
                    done_next   = 1'b1;
                    symbol_next = ref_bit ? SYM_ONE : SYM_ZERO;
                    last_next   = (count_reg == '0);
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (pend_valid_reg && pend_first_reg)
                    begin
                        val_next = pix_rdata;
                    end
                    if (!issue_done_reg)
                    begin
                        // Issue one read and step the scan position.
                        pend_valid_next = 1'b1;
                        pend_first_next = first_reg;
                        pend_last_next  = issue_last;
                        first_next      = 1'b0;
                        issue_done_next = issue_last;
                        if (scan_c_reg == region_reg.c1)
                        begin
                            scan_c_next = region_reg.c0;
                            scan_r_next = scan_r_reg + DIM_W'(1);
                        end
                        else
                        begin
                            scan_c_next = scan_c_reg + DIM_W'(1);
                        end
                    end
                end
            end

            S_PUSH:
            begin
                // Drop the push of an empty quadrant or onto a full stack.
                if (quad_ok && (count_reg < CNT_W'(STACK_DEPTH)))
                begin
                    stk_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                case (quad_reg)
                    Q_BR:    quad_next = Q_BL;
                    Q_BL:    quad_next = Q_TR;
                    Q_TR:    quad_next = Q_TL;
                    default: state_next = S_IDLE;
                endcase
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            loading_reg    <= 1'b1;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            first_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            loading_reg    <= loading_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            first_reg      <= first_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg       <= quad_next;
        region_reg     <= region_next;
        scan_r_reg     <= scan_r_next;
        scan_c_reg     <= scan_c_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        val_reg        <= val_next;
        symbol_reg     <= symbol_next;
        last_reg       <= last_next;
    end

    qtbe_ram #(
        .WIDTH  (1),
        .ADDR_W (PIX_AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pixel),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    qtbe_ram #(
        .WIDTH  (REGION_W),
        .ADDR_W (STK_AW)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // A result strobe is never held high.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // The pending count never passes the stack depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A fetch with nothing pending gives no result and no busy cycle.
    a_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_FETCH) && (count_reg == '0)) |=> (!busy && !done_reg))
        else $error("empty fetch produced activity");

    // A pixel write never makes the block busy.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_WRITE)) |=> !busy)
        else $error("pixel write left the block busy");

    // The final symbol is flagged only once the stack is empty.
    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (count_reg == '0))
        else $error("last flagged with regions pending");

endmodule
